// ===== rtl/utld_pkg.sv =====
// ----------------------------------------------------------------------------
// UTC to local date/time package
// Shared widths, payload structs, constants and calendar helper functions.
// ----------------------------------------------------------------------------
package utld_pkg;

    // Field widths.
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int OFFSET_W = 11;
    localparam int TOTAL_W  = 13;
    localparam int TOD_W    = 11;

    // Configuration port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_UTC_OFFSET = 2'd0;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int PIPE_LATENCY = 4;

    // Time constants.
    localparam logic [TOD_W-1:0] MIN_PER_HOUR = 11'd60;
    localparam logic signed [TOTAL_W-1:0] MIN_PER_DAY = 13'sd1440;
    localparam logic signed [TOTAL_W-1:0] MIN_TWO_DAYS = 13'sd2880;

    // Division of a minute count below one day by 60: (t * 1093) >> 16.
    localparam logic [TOD_W-1:0] HOUR_RECIP = 11'd1093;
    localparam int HOUR_SHIFT = 16;

    // A year is a multiple of 25 exactly when year * inv(25) mod 2^14 does
    // not exceed floor((2^14 - 1) / 25).
    localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

    // Month codes.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Input beat.
    typedef struct packed {
        logic [YEAR_W-1:0]   utc_year;
        logic [MONTH_W-1:0]  utc_month;
        logic [DAY_W-1:0]    utc_day;
        logic [HOUR_W-1:0]   utc_hour;
        logic [MINUTE_W-1:0] utc_minute;
    } utc_stamp_t;

    // Result beat.
    typedef struct packed {
        logic [YEAR_W-1:0]   local_year;
        logic [MONTH_W-1:0]  local_month;
        logic [DAY_W-1:0]    local_day;
        logic [HOUR_W-1:0]   local_hour;
        logic [MINUTE_W-1:0] local_minute;
    } local_stamp_t;

    // Calendar date carried through the pipeline.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // Days in a month; codes outside January to December count as 31 days.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                MONTH_FEB: len = leap ? 5'd29 : 5'd28;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Advance a date by one day. The leap flag belongs to the input year; it
    // stays right because the year only changes when the month becomes January.
    function automatic date_t date_next(input date_t d, input logic leap);
        date_t r;
        logic [DAY_W:0] day_inc;
        begin
            r = d;
            day_inc = {1'b0, d.day} + 6'd1;
            if (day_inc > {1'b0, month_len(d.month, leap)})
            begin
                r.day = 5'd1;
                if (d.month >= MONTH_DEC)
                begin
                    r.month = MONTH_JAN;
                    r.year  = d.year + 14'd1;
                end
                else
                begin
                    r.month = d.month + 4'd1;
                end
            end
            else
            begin
                r.day = day_inc[DAY_W-1:0];
            end
            return r;
        end
    endfunction

    // Step a date back by one day; day 0 or 1 borrows from the previous month.
    function automatic date_t date_prev(input date_t d, input logic leap);
        date_t r;
        begin
            r = d;
            if (d.day <= 5'd1)
            begin
                if (d.month <= MONTH_JAN)
                begin
                    r.month = MONTH_DEC;
                    r.year  = d.year - 14'd1;
                end
                else
                begin
                    r.month = d.month - 4'd1;
                end
                r.day = month_len(r.month, leap);
            end
            else
            begin
                r.day = d.day - 5'd1;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/utld_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// UTC offset configuration register
// APB register bank holding the signed time-zone offset in minutes.
// ----------------------------------------------------------------------------
module utld_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [utld_pkg::PADDR_W-1:0]         paddr,
    input  logic [utld_pkg::PDATA_W-1:0]         pwdata,
    output logic [utld_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    output logic signed [utld_pkg::OFFSET_W-1:0] utc_offset
);

    logic signed [utld_pkg::OFFSET_W-1:0] offset_reg;
    logic signed [utld_pkg::OFFSET_W-1:0] offset_next;
    logic                                 wr_hit;

    // The register accepts every access without wait states.
    assign pready = 1'b1;

    // Write decode for the access phase.
    assign wr_hit = psel && penable && pwrite && (paddr == utld_pkg::ADDR_UTC_OFFSET);

    always_comb
    begin
        offset_next = offset_reg;
        if (wr_hit)
        begin
            offset_next = pwdata[utld_pkg::OFFSET_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    // Read back the offset, sign-extended to the bus width.
    always_comb
    begin
        prdata = '0;
        if (psel && (paddr == utld_pkg::ADDR_UTC_OFFSET))
        begin
            prdata = {{(utld_pkg::PDATA_W - utld_pkg::OFFSET_W){offset_reg[utld_pkg::OFFSET_W-1]}},
                      offset_reg};
        end
    end

    assign utc_offset = offset_reg;

endmodule

// ===== rtl/utc_to_local_date_time.sv =====
// ----------------------------------------------------------------------------
// UTC to local date/time converter
// Adds a signed time-zone offset to a UTC timestamp and carries the result
// across day, month and year boundaries on the Gregorian calendar.
// ----------------------------------------------------------------------------
// Usage:
// - Program the offset in minutes over the APB port (address 0) while no beat
//   is in flight. It resets to 0, so after reset the output equals the input.
// - Drive a UTC timestamp on utc_stamp and pulse start. busy stays low, so a
//   beat is taken at every edge where start is high, one beat per cycle.
// - Each beat gives exactly one result on local_stamp, marked by done for
//   one cycle.
// - Four register stages set the latency: minute-of-day sum and year
//   divisibility product, day carry decision, date step and hour division,
//   minute remainder into the output register.
// - The receiver cannot stall; results appear in the order the beats came.
// - Reset clears the valid bits of every stage, dropping beats in flight.
// ----------------------------------------------------------------------------
module utc_to_local_date_time (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [utld_pkg::PADDR_W-1:0] paddr,
    input  logic [utld_pkg::PDATA_W-1:0] pwdata,
    output logic [utld_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  utld_pkg::utc_stamp_t         utc_stamp,
    output logic                         done,
    output utld_pkg::local_stamp_t       local_stamp
);

    typedef enum logic [1:0] {
        ADJ_NONE   = 2'd0,
        ADJ_BORROW = 2'd1,
        ADJ_CARRY1 = 2'd2,
        ADJ_CARRY2 = 2'd3
    } adj_t;

    logic signed [utld_pkg::OFFSET_W-1:0] utc_offset;
    logic                                 accept;

    // Stage 1 signals.
    logic [utld_pkg::TOD_W-1:0]           hm_s1;
    logic signed [utld_pkg::TOTAL_W-1:0]  total_s1;
    logic [2*utld_pkg::YEAR_W-1:0]        yprod_s1;
    logic                                 v1_reg;
    utld_pkg::date_t                      date1_reg;
    logic signed [utld_pkg::TOTAL_W-1:0]  total1_reg;
    logic [utld_pkg::YEAR_W-1:0]          yprod1_reg;

    // Stage 2 signals.
    logic                                 div25_s2;
    logic                                 leap_s2;
    adj_t                                 adj_s2;
    logic signed [utld_pkg::TOTAL_W-1:0]  tod_wide_s2;
    logic                                 v2_reg;
    utld_pkg::date_t                      date2_reg;
    logic                                 leap2_reg;
    adj_t                                 adj2_reg;
    logic [utld_pkg::TOD_W-1:0]           tod2_reg;

    // Stage 3 signals.
    utld_pkg::date_t                      date_s3;
    logic [2*utld_pkg::TOD_W-1:0]         hprod_s3;
    logic                                 v3_reg;
    utld_pkg::date_t                      date3_reg;
    logic [utld_pkg::TOD_W-1:0]           tod3_reg;
    logic [utld_pkg::HOUR_W-1:0]          hour3_reg;

    // Stage 4 signals.
    logic [utld_pkg::TOD_W-1:0]           minute_s4;
    logic                                 done_reg;
    utld_pkg::local_stamp_t               out_reg;

    utld_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .utc_offset (utc_offset)
    );

    // The pipeline takes a beat in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Stage 1: minutes past midnight plus offset, and the year times inv(25).
    always_comb
    begin
        hm_s1 = utld_pkg::TOD_W'(utc_stamp.utc_hour) * utld_pkg::MIN_PER_HOUR
              + utld_pkg::TOD_W'(utc_stamp.utc_minute);
        total_s1 = $signed({2'b00, hm_s1})
                 + $signed({{(utld_pkg::TOTAL_W - utld_pkg::OFFSET_W){utc_offset[utld_pkg::OFFSET_W-1]}},
                            utc_offset});
        yprod_s1 = (2*utld_pkg::YEAR_W)'(utc_stamp.utc_year)
                 * (2*utld_pkg::YEAR_W)'(utld_pkg::INV25);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            date1_reg.year  <= utc_stamp.utc_year;
            date1_reg.month <= utc_stamp.utc_month;
            date1_reg.day   <= utc_stamp.utc_day;
            total1_reg      <= total_s1;
            yprod1_reg      <= yprod_s1[utld_pkg::YEAR_W-1:0];
        end
    end

    // Stage 2: leap year flag, day carry or borrow, and the wrapped minute count.
    always_comb
    begin
        div25_s2 = (yprod1_reg <= utld_pkg::DIV25_LIMIT);
        leap_s2  = ((date1_reg.year[1:0] == 2'd0) && !div25_s2)
                || ((date1_reg.year[3:0] == 4'd0) && div25_s2);
        priority if (total1_reg < 0)
        begin
            adj_s2      = ADJ_BORROW;
            tod_wide_s2 = total1_reg + utld_pkg::MIN_PER_DAY;
        end
        else if (total1_reg >= utld_pkg::MIN_TWO_DAYS)
        begin
            adj_s2      = ADJ_CARRY2;
            tod_wide_s2 = total1_reg - utld_pkg::MIN_TWO_DAYS;
        end
        else if (total1_reg >= utld_pkg::MIN_PER_DAY)
        begin
            adj_s2      = ADJ_CARRY1;
            tod_wide_s2 = total1_reg - utld_pkg::MIN_PER_DAY;
        end
        else
        begin
            adj_s2      = ADJ_NONE;
            tod_wide_s2 = total1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            date2_reg <= date1_reg;
            leap2_reg <= leap_s2;
            adj2_reg  <= adj_s2;
            tod2_reg  <= tod_wide_s2[utld_pkg::TOD_W-1:0];
        end
    end

    // Stage 3: step the date and divide the minute count by 60.
    always_comb
    begin
        unique case (adj2_reg)
            ADJ_BORROW: date_s3 = utld_pkg::date_prev(date2_reg, leap2_reg);
            ADJ_CARRY1: date_s3 = utld_pkg::date_next(date2_reg, leap2_reg);
            ADJ_CARRY2: date_s3 = utld_pkg::date_next(
                                      utld_pkg::date_next(date2_reg, leap2_reg), leap2_reg);
            default:    date_s3 = date2_reg;
        endcase
        hprod_s3 = (2*utld_pkg::TOD_W)'(tod2_reg) * (2*utld_pkg::TOD_W)'(utld_pkg::HOUR_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            date3_reg <= date_s3;
            tod3_reg  <= tod2_reg;
            hour3_reg <= hprod_s3[utld_pkg::HOUR_SHIFT +: utld_pkg::HOUR_W];
        end
    end

    // Stage 4: minute remainder and the output register.
    always_comb
    begin
        minute_s4 = tod3_reg - utld_pkg::TOD_W'(hour3_reg) * utld_pkg::MIN_PER_HOUR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            out_reg.local_year   <= date3_reg.year;
            out_reg.local_month  <= date3_reg.month;
            out_reg.local_day    <= date3_reg.day;
            out_reg.local_hour   <= hour3_reg;
            out_reg.local_minute <= minute_s4[utld_pkg::MINUTE_W-1:0];
        end
    end

    assign done        = done_reg;
    assign local_stamp = out_reg;

endmodule

// ===== rtl/utld_checker.sv =====
// ----------------------------------------------------------------------------
// UTC to local date/time checker
// Port-level assertions on result timing and time-of-day range.
// ----------------------------------------------------------------------------
module utld_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input utld_pkg::local_stamp_t local_stamp
);

    // Every accepted beat produces a result after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(utld_pkg::PIPE_LATENCY) done)
    else $error("accepted beat produced no result");

    // No result appears without a beat accepted one latency earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, utld_pkg::PIPE_LATENCY))
    else $error("result without a matching accepted beat");

    // The local time of day is always normalized.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((local_stamp.local_hour < 5'd24) && (local_stamp.local_minute < 6'd60)))
    else $error("local time of day out of range");

endmodule

bind utc_to_local_date_time utld_checker u_utld_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .local_stamp (local_stamp)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// UTC to local date/time testbench
// Sends UTC stamps through the command port under several programmed zone
// offsets and compares every local stamp against an in-bench calendar
// predictor. Offsets are written and read back over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DAY_MINUTES = 24 * 60;
    localparam int YEAR_MASK   = (1 << utld_pkg::YEAR_W) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 75;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [utld_pkg::PADDR_W-1:0]  paddr = '0;
    logic [utld_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [utld_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    logic                          start = 1'b0;
    logic                          busy;
    utld_pkg::utc_stamp_t          utc_stamp = '0;
    logic                          done;
    utld_pkg::local_stamp_t        local_stamp;

    // Stamps waiting to be sent and local stamps waiting to come back.
    utld_pkg::utc_stamp_t          pending_stamps[$];
    utld_pkg::local_stamp_t        expected_local[$];

    // Offset currently programmed in the block, as the predictor sees it.
    logic signed [utld_pkg::OFFSET_W-1:0] zone_offset = '0;

    int mismatch_count = 0;
    int stall_cycles = 0;
    bit timed_out = 1'b0;

    // Sender burst shaping.
    int burst_left = 1;
    int gap_left = 0;

    utc_to_local_date_time u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .utc_stamp   (utc_stamp),
        .done        (done),
        .local_stamp (local_stamp)
    );

    // Clock generation.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Gregorian month length; codes outside January to December count as 31.
    function automatic int days_in_month(int m, int y);
        bit leap;
        begin
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m == int'(utld_pkg::MONTH_FEB))
                return leap ? 29 : 28;
            if (m == int'(utld_pkg::MONTH_APR) || m == int'(utld_pkg::MONTH_JUN) ||
                m == int'(utld_pkg::MONTH_SEP) || m == int'(utld_pkg::MONTH_NOV))
                return 30;
            return 31;
        end
    endfunction

    // Local stamp for one UTC stamp under the given zone offset.
    function automatic utld_pkg::local_stamp_t to_local_time(
        utld_pkg::utc_stamp_t s, logic signed [utld_pkg::OFFSET_W-1:0] off);
        int year;
        int month;
        int day;
        int total;
        utld_pkg::local_stamp_t r;
        begin
            year  = int'(s.utc_year);
            month = int'(s.utc_month);
            day   = int'(s.utc_day);
            total = int'(s.utc_hour) * 60 + int'(s.utc_minute) + int'(off);

            // A negative minute count borrows one day.
            if (total < 0)
            begin
                total += DAY_MINUTES;
                if (day <= 1)
                begin
                    if (month <= int'(utld_pkg::MONTH_JAN))
                    begin
                        month = int'(utld_pkg::MONTH_DEC);
                        year  = (year - 1) & YEAR_MASK;
                    end
                    else
                    begin
                        month = month - 1;
                    end
                    day = days_in_month(month, year);
                end
                else
                begin
                    day = day - 1;
                end
            end

            // Each whole day above midnight is carried in turn.
            for (int k = 0; k < 3 && total >= DAY_MINUTES; k++)
            begin
                total -= DAY_MINUTES;
                day = day + 1;
                if (day > days_in_month(month, year))
                begin
                    day = 1;
                    if (month >= int'(utld_pkg::MONTH_DEC))
                    begin
                        month = int'(utld_pkg::MONTH_JAN);
                        year  = (year + 1) & YEAR_MASK;
                    end
                    else
                    begin
                        month = month + 1;
                    end
                end
            end

            r.local_year   = year[utld_pkg::YEAR_W-1:0];
            r.local_month  = month[utld_pkg::MONTH_W-1:0];
            r.local_day    = day[utld_pkg::DAY_W-1:0];
            r.local_hour   = utld_pkg::HOUR_W'(total / 60);
            r.local_minute = utld_pkg::MINUTE_W'(total % 60);
            return r;
        end
    endfunction

    // Count a mismatch and report the first few.
    function automatic void check_field(string name, int want, int got);
        begin
            if (want != got)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] %s: expected %0d, got %0d", $realtime, name, want, got);
            end
        end
    endfunction

    // Sender: bursts of beats separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            utc_stamp <= '0;
        end
        else if (!start || !busy)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_stamps.size() > 0)
            begin
                utc_stamp <= pending_stamps.pop_front();
                start     <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict on every accepted beat, check every result beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_local.push_back(to_local_time(utc_stamp, zone_offset));

            if (done)
            begin
                if (expected_local.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] result beat with nothing expected: %p",
                                 $realtime, local_stamp);
                end
                else
                begin
                    utld_pkg::local_stamp_t want;
                    want = expected_local.pop_front();
                    check_field("local_year", want.local_year, local_stamp.local_year);
                    check_field("local_month", want.local_month, local_stamp.local_month);
                    check_field("local_day", want.local_day, local_stamp.local_day);
                    check_field("local_hour", want.local_hour, local_stamp.local_hour);
                    check_field("local_minute", want.local_minute,
                                local_stamp.local_minute);
                end
            end

            // Stall watchdog: any accepted beat, result beat or register access counts as progress.
            if ((start && !busy) || done || (psel && penable))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // One APB transfer to the offset register; returns read data.
    task automatic offset_reg_access(input logic wr,
                                     input logic [utld_pkg::OFFSET_W-1:0] val,
                                     output logic [utld_pkg::PDATA_W-1:0] rd);
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= utld_pkg::ADDR_UTC_OFFSET;
            pwdata  <= {{(utld_pkg::PDATA_W-utld_pkg::OFFSET_W){val[utld_pkg::OFFSET_W-1]}},
                        val};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            rd = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Let every queued beat go through and the pipeline drain.
    task automatic wait_quiet();
        begin
            do
                @(negedge clk);
            while (pending_stamps.size() != 0 || start || expected_local.size() != 0);
            repeat (utld_pkg::PIPE_LATENCY + 2) @(negedge clk);
        end
    endtask

    // Program a new offset while idle, then read it back.
    task automatic set_zone_offset(input int minutes);
        logic [utld_pkg::OFFSET_W-1:0] val;
        logic [utld_pkg::PDATA_W-1:0] rd;
        begin
            val = minutes[utld_pkg::OFFSET_W-1:0];
            wait_quiet();
            offset_reg_access(1'b1, val, rd);
            zone_offset = val;
            offset_reg_access(1'b0, '0, rd);
            check_field("offset readback", int'(val), int'(rd[utld_pkg::OFFSET_W-1:0]));
            @(negedge clk);
        end
    endtask

    function automatic void push_stamp(int y, int m, int d, int h, int mi);
        utld_pkg::utc_stamp_t s;
        begin
            s.utc_year   = y[utld_pkg::YEAR_W-1:0];
            s.utc_month  = m[utld_pkg::MONTH_W-1:0];
            s.utc_day    = d[utld_pkg::DAY_W-1:0];
            s.utc_hour   = h[utld_pkg::HOUR_W-1:0];
            s.utc_minute = mi[utld_pkg::MINUTE_W-1:0];
            pending_stamps.push_back(s);
        end
    endfunction

    // Valid date and time, biased toward month starts and ends, midnight and century years.
    function automatic void push_valid_stamp();
        int y;
        int m;
        int d;
        int len;
        int h;
        int mi;
        begin
            case ($urandom_range(0, 9))
                0: y = $urandom_range(1, 99) * 100;
                1: y = $urandom_range(1, 24) * 400;
                2: y = $urandom_range(1, 2499) * 4;
                3: y = $urandom_range(0, 1) ? 1 : 9999;
                default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(1, 12);
            len = days_in_month(m, y);
            case ($urandom_range(0, 9))
                0, 1: d = 1;
                2, 3: d = len;
                4: d = len - 1;
                default: d = $urandom_range(1, len);
            endcase
            h  = ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 1) ? 23 : 0)
                                            : $urandom_range(0, 23);
            mi = ($urandom_range(0, 9) < 3) ? ($urandom_range(0, 1) ? 59 : 0)
                                            : $urandom_range(0, 59);
            push_stamp(y, m, d, h, mi);
        end
    endfunction

    // Any bit pattern at all, covering fields beyond their nominal ranges.
    function automatic void push_noise_stamp();
        logic [63:0] r;
        begin
            r = {$urandom, $urandom};
            pending_stamps.push_back(r[$bits(utld_pkg::utc_stamp_t)-1:0]);
        end
    endfunction

    task automatic run_stimulus();
        int offs[10];
        begin
            // Reset offset of zero: field extremes pass straight through or carry once.
            push_stamp(0, 1, 1, 0, 0);
            push_stamp(16383, 15, 31, 31, 63);
            push_stamp(9999, 12, 31, 23, 59);
            push_stamp(2024, 2, 29, 12, 30);
            push_stamp(1, 1, 1, 0, 0);

            // Largest positive offset: carries into next day, month and year.
            set_zone_offset(1023);
            push_stamp(9999, 12, 31, 23, 59);
            push_stamp(2000, 2, 28, 23, 0);
            push_stamp(1900, 2, 28, 23, 0);
            push_stamp(2024, 2, 29, 23, 0);
            push_stamp(16383, 12, 31, 23, 59);
            push_stamp(2023, 6, 0, 23, 0);
            push_stamp(2023, 4, 30, 31, 63);
            push_stamp(2023, 7, 15, 0, 0);

            // Most negative offset: borrows from previous day, month and year.
            set_zone_offset(-1024);
            push_stamp(1, 1, 1, 0, 0);
            push_stamp(0, 1, 1, 0, 0);
            push_stamp(2000, 3, 1, 0, 0);
            push_stamp(2100, 3, 1, 0, 0);
            push_stamp(2023, 5, 0, 0, 0);
            push_stamp(2023, 0, 1, 0, 0);
            push_stamp(2023, 14, 1, 0, 0);
            push_stamp(2023, 5, 1, 0, 0);
            push_stamp(2023, 8, 20, 23, 59);

            // Random phases, each under its own offset.
            offs[0] = 840;
            offs[1] = -720;
            offs[2] = 1;
            offs[3] = -1;
            offs[4] = int'($urandom_range(0, 1560)) - 720;
            offs[5] = int'($urandom_range(0, 1560)) - 720;
            offs[6] = int'($urandom_range(0, 2047));
            offs[7] = int'($urandom_range(0, 2047));
            offs[8] = 1023;
            offs[9] = -1024;
            foreach (offs[p])
            begin
                set_zone_offset(offs[p]);
                for (int i = 0; i < PHASE_BEATS; i++)
                begin
                    if ($urandom_range(0, 99) < 85)
                        push_valid_stamp();
                    else
                        push_noise_stamp();
                end
            end

            wait_quiet();
        end
    endtask

    // Reset, stimulus and final verdict.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        fork
            run_stimulus();
            begin
                wait (stall_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && mismatch_count == 0)
            $display("utc_to_local_date_time: match");
        else
            $display("utc_to_local_date_time: mismatch");
        $finish;
    end

endmodule
